/* rtl/core/gpcm_pkg.sv */
// Shared types and constants for the grid point cell membership block.
`default_nettype none

package gpcm_pkg;

	// Field widths of the result beat
	localparam int IDX_W = 30;
	localparam int TAG_W = 30;

	// Register port geometry
	localparam int APB_DW = 32;
	localparam int APB_AW = 4;

	// Cells that may own one lattice point
	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = 3;

	// Register map, one word per register
	typedef enum logic [1:0] {
		REG_CELLS_X = 2'd0,
		REG_CELLS_Y = 2'd1,
		REG_CELLS_Z = 2'd2
	} gpcm_reg_t;

	// Neighbour offsets in emission order: bit 0 is +x, bit 1 is +y, bit 2 is +z
	localparam logic [SLOT_W-1:0] STEP_ORDER [NUM_SLOTS] = '{
		3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
	};

	// One classified point waiting for expansion
	typedef struct packed {
		logic [IDX_W-1:0]  base;
		logic [TAG_W-1:0]  tag;
		logic [SLOT_W-1:0] steps;
		logic              oor;
	} gpcm_entry_t;

	// Queue status seen by the expansion side
	typedef struct packed {
		logic empty;
		logic full;
	} gpcm_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/gpcm_if.sv */
// Valid/ready channel interfaces for lattice points in and cell memberships out.
`default_nettype none

interface gpcm_in_if #(parameter int AXIS_BITS = 10);
	import gpcm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [AXIS_BITS-1:0] coord_x;
	logic [AXIS_BITS-1:0] coord_y;
	logic [AXIS_BITS-1:0] coord_z;
	logic [TAG_W-1:0]     point_number;

	modport source (output valid, coord_x, coord_y, coord_z, point_number, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, point_number, output ready);
endinterface

interface gpcm_out_if;
	import gpcm_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] cell_number;
	logic [TAG_W-1:0] point_tag;
	logic             last_of_run;
	logic             out_of_range;

	modport source (output valid, cell_number, point_tag, last_of_run, out_of_range,
		input ready);
	modport sink   (input valid, cell_number, point_tag, last_of_run, out_of_range,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/gpcm_regs.sv */
// Grid extent registers on the APB-style port, with the cached xy plane size.
`default_nettype none

module gpcm_regs #(
	parameter int AXIS_BITS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gpcm_pkg::APB_AW-1:0] paddr,
	input  wire logic [gpcm_pkg::APB_DW-1:0] pwdata,
	output logic      [gpcm_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	output logic      [AXIS_BITS-1:0]        cells_x,
	output logic      [AXIS_BITS-1:0]        cells_y,
	output logic      [AXIS_BITS-1:0]        cells_z,
	output logic      [gpcm_pkg::IDX_W-1:0]  plane_size
);
	import gpcm_pkg::*;

	localparam int PW = 2 * AXIS_BITS;

	logic [AXIS_BITS-1:0] cells_x_q;
	logic [AXIS_BITS-1:0] cells_y_q;
	logic [AXIS_BITS-1:0] cells_z_q;
	logic [IDX_W-1:0]     plane_q;
	logic [PW-1:0]        plane_full;
	logic                 wr_en;
	gpcm_reg_t            reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = gpcm_reg_t'(paddr[APB_AW-1:2]);

	// Write the addressed register; other addresses are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= AXIS_BITS'(1);
			cells_y_q <= AXIS_BITS'(1);
			cells_z_q <= AXIS_BITS'(1);
		end else if (wr_en) begin
			case (reg_sel)
				REG_CELLS_X: cells_x_q <= pwdata[AXIS_BITS-1:0];
				REG_CELLS_Y: cells_y_q <= pwdata[AXIS_BITS-1:0];
				REG_CELLS_Z: cells_z_q <= pwdata[AXIS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Keep the cells per xy plane, registered the cycle after the extent registers
	assign plane_full = PW'(cells_x_q) * PW'(cells_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= IDX_W'(1);
		end else begin
			plane_q <= IDX_W'(plane_full);
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_CELLS_X: prdata = APB_DW'(cells_x_q);
			REG_CELLS_Y: prdata = APB_DW'(cells_y_q);
			REG_CELLS_Z: prdata = APB_DW'(cells_z_q);
			default:     prdata = '0;
		endcase
	end

	assign cells_x    = cells_x_q;
	assign cells_y    = cells_y_q;
	assign cells_z    = cells_z_q;
	assign plane_size = plane_q;

endmodule

`default_nettype wire

/* rtl/core/gpcm_front.sv */
// Front end: accept points, classify them and form the base cell index.
`default_nettype none

module gpcm_front #(
	parameter int AXIS_BITS = 10,
	parameter int QDEPTH    = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	gpcm_in_if.sink                         point,
	input  wire logic [AXIS_BITS-1:0]       cells_x,
	input  wire logic [AXIS_BITS-1:0]       cells_y,
	input  wire logic [AXIS_BITS-1:0]       cells_z,
	input  wire logic [gpcm_pkg::IDX_W-1:0] plane_size,
	input  wire logic                       pop,
	output logic                            push,
	output gpcm_pkg::gpcm_entry_t           push_data
);
	import gpcm_pkg::*;

	localparam int CW = $clog2(QDEPTH + 1);
	localparam int YW = 2 * AXIS_BITS;
	localparam int ZW = AXIS_BITS + IDX_W;

	logic [CW-1:0]        credit_q;
	logic                 accept;

	logic                 v_s1;
	logic [AXIS_BITS-1:0] bx_s1;
	logic [AXIS_BITS-1:0] by_s1;
	logic [AXIS_BITS-1:0] bz_s1;
	logic [SLOT_W-1:0]    steps_s1;
	logic                 oor_s1;
	logic [TAG_W-1:0]     tag_s1;

	logic                 v_s2;
	logic [AXIS_BITS-1:0] bx_s2;
	logic [IDX_W-1:0]     py_s2;
	logic [IDX_W-1:0]     pz_s2;
	logic [SLOT_W-1:0]    steps_s2;
	logic                 oor_s2;
	logic [TAG_W-1:0]     tag_s2;

	logic [YW-1:0]        py_full;
	logic [ZW-1:0]        pz_full;

	// Take a point only while a queue slot is reserved for it
	assign point.ready = (credit_q < CW'(QDEPTH));
	assign accept      = point.valid & point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   credit_q <= credit_q + CW'(1);
				2'b01:   credit_q <= credit_q - CW'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Stage 1: range check, base corner and forward steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bx_s1 <= (point.coord_x != '0) ? point.coord_x - AXIS_BITS'(1) : '0;
			by_s1 <= (point.coord_y != '0) ? point.coord_y - AXIS_BITS'(1) : '0;
			bz_s1 <= (point.coord_z != '0) ? point.coord_z - AXIS_BITS'(1) : '0;
			steps_s1[0] <= (point.coord_x != '0) && (point.coord_x < cells_x);
			steps_s1[1] <= (point.coord_y != '0) && (point.coord_y < cells_y);
			steps_s1[2] <= (point.coord_z != '0) && (point.coord_z < cells_z);
			oor_s1 <= (point.coord_x > cells_x) || (point.coord_y > cells_y)
				|| (point.coord_z > cells_z);
			tag_s1 <= point.point_number;
		end
	end

	// Stage 2: row and plane offsets of the base cell
	assign py_full = YW'(by_s1) * YW'(cells_x);
	assign pz_full = ZW'(bz_s1) * ZW'(plane_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			bx_s2    <= bx_s1;
			py_s2    <= IDX_W'(py_full);
			pz_s2    <= IDX_W'(pz_full);
			steps_s2 <= steps_s1;
			oor_s2   <= oor_s1;
			tag_s2   <= tag_s1;
		end
	end

	// Sum the base index and hand the point to the queue
	assign push            = v_s2;
	assign push_data.base  = IDX_W'(bx_s2) + py_s2 + pz_s2;
	assign push_data.tag   = tag_s2;
	assign push_data.steps = steps_s2;
	assign push_data.oor   = oor_s2;

endmodule

`default_nettype wire

/* rtl/core/gpcm_queue.sv */
// Short queue of classified points between the front and back ends.
`default_nettype none

module gpcm_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire gpcm_pkg::gpcm_entry_t push_data,
	input  wire logic                  pop,
	output gpcm_pkg::gpcm_entry_t      head,
	output gpcm_pkg::gpcm_qstat_t      stat
);
	import gpcm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gpcm_entry_t   slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

endmodule

`default_nettype wire

/* rtl/core/gpcm_back.sv */
// Back end: expand head points into owning cells, one beat a cycle while ready.
`default_nettype none

module gpcm_back #(
	parameter int AXIS_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire gpcm_pkg::gpcm_entry_t      head,
	input  wire gpcm_pkg::gpcm_qstat_t      stat,
	input  wire logic [AXIS_BITS-1:0]       cells_x,
	input  wire logic [gpcm_pkg::IDX_W-1:0] plane_size,
	output logic                            pop,
	gpcm_out_if.source                      member
);
	import gpcm_pkg::*;

	logic [SLOT_W-1:0]    slot_q;
	logic [NUM_SLOTS-1:0] sel;
	logic [NUM_SLOTS-1:0] rest;
	logic [SLOT_W-1:0]    pos;
	logic                 found;
	logic [SLOT_W-1:0]    step;
	logic                 last;
	logic [IDX_W-1:0]     cell_idx;
	logic                 emit;

	logic                 ov_q;
	logic [IDX_W-1:0]     cell_q;
	logic [TAG_W-1:0]     tag_q;
	logic                 last_q;
	logic                 oor_q;

	// Pick the next owning cell at or after the current slot
	always_comb begin
		sel   = '0;
		pos   = '0;
		found = 1'b0;
		for (int m = 0; m < NUM_SLOTS; m++) begin
			sel[m] = ((STEP_ORDER[m] & ~head.steps) == '0) && (SLOT_W'(m) >= slot_q);
		end
		if (head.oor) begin
			sel = NUM_SLOTS'(1);
		end
		for (int m = 0; m < NUM_SLOTS; m++) begin
			if (sel[m] && !found) begin
				pos   = SLOT_W'(m);
				found = 1'b1;
			end
		end
		rest = sel & ~(NUM_SLOTS'(1) << pos);
		last = (rest == '0);
		step = STEP_ORDER[pos];
		cell_idx = head.base + IDX_W'(step[0])
			+ (step[1] ? IDX_W'(cells_x) : '0)
			+ (step[2] ? plane_size : '0);
		if (head.oor) begin
			cell_idx = '0;
		end
	end

	// Load the output register when a point is queued and it is free or draining
	assign emit = !stat.empty && (!ov_q || member.ready);
	assign pop  = emit && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (emit) begin
				slot_q <= last ? '0 : pos + SLOT_W'(1);
				ov_q   <= 1'b1;
			end else if (member.ready) begin
				ov_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cell_q <= cell_idx;
			tag_q  <= head.tag;
			last_q <= last;
			oor_q  <= head.oor;
		end
	end

	assign member.valid        = ov_q;
	assign member.cell_number  = cell_q;
	assign member.point_tag    = tag_q;
	assign member.last_of_run  = last_q;
	assign member.out_of_range = oor_q;

endmodule

`default_nettype wire

/* rtl/core/grid_point_cell_membership_core.sv */
// Top level of the grid point cell membership block.
//
// Usage: write the cell counts of the grid (x, y, z) over the APB-style port
// while the block is idle, then feed lattice points on the point channel.
// Each accepted point yields, on the member channel, one beat per cell that
// has the point as a corner: base cell, then +x, +y, +z, +xy, +xz, +yz, +xyz,
// with last_of_run set on the final beat. A point outside the grid yields one
// beat with out_of_range set and cell_number zero.
// Each point passes stage 1, stage 2, the queue and the result register.
// Throughput: one beat a cycle while member.ready is high and a point is
// queued; a point with n owning cells yields n beats (eight at most, one for
// a grid corner or out-of-range point); the shared result register sets it.
// The front end keeps taking points while a queue slot is free, so short runs
// follow one another without gaps. A stalled member channel holds its beat
// and fills the queue, after which point.ready falls.
// Reset clears the queue, pipeline and output valid, and sets all cell counts
// to one.
`default_nettype none

module grid_point_cell_membership_core #(
	parameter int AXIS_BITS   = 10,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gpcm_pkg::APB_AW-1:0] paddr,
	input  wire logic [gpcm_pkg::APB_DW-1:0] pwdata,
	output logic      [gpcm_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	gpcm_in_if.sink                          point,
	gpcm_out_if.source                       member
);
	import gpcm_pkg::*;

	logic [AXIS_BITS-1:0] cells_x;
	logic [AXIS_BITS-1:0] cells_y;
	logic [AXIS_BITS-1:0] cells_z;
	logic [IDX_W-1:0]     plane_size;
	logic                 q_push;
	logic                 q_pop;
	gpcm_entry_t          q_in;
	gpcm_entry_t          q_head;
	gpcm_qstat_t          q_stat;

	gpcm_regs #(
		.AXIS_BITS (AXIS_BITS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cells_x    (cells_x),
		.cells_y    (cells_y),
		.cells_z    (cells_z),
		.plane_size (plane_size)
	);

	gpcm_front #(
		.AXIS_BITS (AXIS_BITS),
		.QDEPTH    (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point      (point),
		.cells_x    (cells_x),
		.cells_y    (cells_y),
		.cells_z    (cells_z),
		.plane_size (plane_size),
		.pop        (q_pop),
		.push       (q_push),
		.push_data  (q_in)
	);

	gpcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	gpcm_back #(
		.AXIS_BITS (AXIS_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.stat       (q_stat),
		.cells_x    (cells_x),
		.plane_size (plane_size),
		.pop        (q_pop),
		.member     (member)
	);

	// Reserved slots keep the queue from overflowing
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue pushed while full");

	// Only a held point is retired
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// Retiring a point loads its final beat
	a_pop_loads_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (member.valid && member.last_of_run))
		else $error("retired point without a final beat");

	// An out-of-range beat stands alone with a zero cell index
	a_oor_single: assert property (@(posedge clk) disable iff (!arst_n)
		(member.valid && member.out_of_range)
		|-> (member.last_of_run && (member.cell_number == '0)))
		else $error("malformed out-of-range beat");

endmodule

`default_nettype wire
